>>> hw/rtl/pwe_pkg.sv
// Shared types, widths and codes for the piecewise-linear waveform evaluator.
package pwe_pkg;

	localparam int MAX_POINTS = 64;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	localparam int TIME_W  = 32;
	localparam int AMP_W   = 24;
	localparam int AXIS_W  = 2;
	localparam int OP_W    = 2;
	localparam int RES_W   = 63;
	localparam int SUM_W   = 64;
	localparam int REL_W   = TIME_W + 2;   // signed time relative to start
	localparam int MUL_A_W = AMP_W + 2;    // amplitude difference or sum
	localparam int MUL_B_W = TIME_W + 1;   // non-negative time span
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	localparam logic signed [SUM_W-1:0] SUM_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - 64'sd1;

	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
	localparam logic [OP_W-1:0] OP_AMP   = 2'd2;
	localparam logic [OP_W-1:0] OP_MOM   = 2'd3;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_AXIS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]          opcode;
		logic [TIME_W-1:0]        point_time;
		logic signed [AMP_W-1:0]  point_amplitude;
		logic [AXIS_W-1:0]        query_axis;
		logic [TIME_W-1:0]        time_from;
		logic [TIME_W-1:0]        time_to;
	} in_item_t;

	typedef struct packed {
		logic signed [RES_W-1:0] result_value;
		logic                    status;
	} out_item_t;

	typedef struct packed {
		logic [TIME_W-1:0]       tm;
		logic signed [AMP_W-1:0] amp;
	} entry_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_EVAL,
		ST_IMUL,
		ST_IDIV,
		ST_IWAIT,
		ST_FMUL,
		ST_ACC,
		ST_DONE
	} state_t;

endpackage

>>> hw/rtl/pwe_ram.sv
// Breakpoint table: one write port, one registered read port.
module pwe_ram (
	input  logic                        clk,
	input  logic                        we,
	input  logic [pwe_pkg::ADDR_W-1:0]  waddr,
	input  pwe_pkg::entry_t             wdata,
	input  logic                        re,
	input  logic [pwe_pkg::ADDR_W-1:0]  raddr,
	output pwe_pkg::entry_t             rdata
);

	pwe_pkg::entry_t mem [pwe_pkg::MAX_POINTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/pwe_div.sv
// Radix-2 restoring divider, signed dividend by unsigned divisor, truncates toward zero.
module pwe_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [pwe_pkg::PROD_W-1:0]   dividend,
	input  logic [pwe_pkg::TIME_W-1:0]          divisor,
	output logic signed [pwe_pkg::MUL_A_W-1:0]  quotient,
	output pwe_pkg::div_stat_t                  stat
);

	localparam int CW = $clog2(pwe_pkg::PROD_W + 1);

	logic [pwe_pkg::PROD_W-1:0] quo_q;
	logic [pwe_pkg::TIME_W-1:0] rem_q;
	logic [pwe_pkg::TIME_W-1:0] dsr_q;
	logic                       neg_q;
	logic [CW-1:0]              cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [pwe_pkg::PROD_W-1:0] mag;
	logic [pwe_pkg::TIME_W:0]   trial;
	logic                       fits;
	logic [pwe_pkg::MUL_A_W-1:0] qlow;

	assign mag   = dividend[pwe_pkg::PROD_W-1] ? pwe_pkg::PROD_W'(-dividend)
	                                           : pwe_pkg::PROD_W'(dividend);
	assign trial = {rem_q, quo_q[pwe_pkg::PROD_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};
	assign qlow  = quo_q[pwe_pkg::MUL_A_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(pwe_pkg::PROD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag;
			rem_q <= '0;
			dsr_q <= divisor;
			neg_q <= dividend[pwe_pkg::PROD_W-1];
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= pwe_pkg::TIME_W'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= trial[pwe_pkg::TIME_W-1:0];
			end
			quo_q <= {quo_q[pwe_pkg::PROD_W-2:0], fits};
		end
	end

	assign quotient = neg_q ? $signed(-qlow) : $signed(qlow);
	assign stat     = '{busy: busy_q, done: done_q};

endmodule

>>> hw/rtl/piecewise_linear_waveform_evaluator.sv
// Top level: config registers, table sequencer, multiplier and result register.
//
// Usage:
//   cfg channel  - write waveform_axis (index 0), waveform_start (1) and
//                  waveform_length (2); cfg_ready is always high, unknown
//                  indexes are dropped. Write only while no request is open.
//   in channel   - one request per handshake: clear, load breakpoint,
//                  amplitude query or moment query. Taken only when the
//                  sequencer is idle; it may be taken while a finished result
//                  still sits in the output register.
//   out channel  - one result per request, in request order.
// Sequence: a clear or load goes straight from the taken request to the done
//   state, and its result is registered in the output register once that
//   register is free; the next request can follow once the sequencer is idle.
//   Queries read the table one entry at a time. An interpolation costs one
//   multiply plus a full run of the serial divider; a moment segment costs up
//   to two interpolations plus one multiply and accumulate.
// Reset: table count cleared, axis 1, start 0, length 0. The table memory
//   itself is not cleared; only entries below the count are read.
// Stall: a held result blocks the next finish, not the next request.
module piecewise_linear_waveform_evaluator (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  pwe_pkg::in_item_t                     in_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output pwe_pkg::out_item_t                    out_data,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pwe_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [pwe_pkg::TIME_W-1:0]            cfg_data
);

	// configuration
	logic [pwe_pkg::AXIS_W-1:0] axis_q;
	logic [pwe_pkg::TIME_W-1:0] start_q;
	logic [pwe_pkg::TIME_W-1:0] length_q;

	// control
	pwe_pkg::state_t            state_q, state_d;
	logic [pwe_pkg::CNT_W-1:0]  count_q;
	logic [pwe_pkg::CNT_W-1:0]  idx_q;
	logic                       out_valid_q;
	pwe_pkg::out_item_t         out_q;

	// request context
	logic [pwe_pkg::OP_W-1:0]        op_q;
	logic signed [pwe_pkg::REL_W-1:0] t1_q, t2_q;
	logic [pwe_pkg::TIME_W-1:0]      prev_time_q, cur_time_q;
	logic signed [pwe_pkg::AMP_W-1:0] prev_amp_q, cur_amp_q;
	logic                            nm1_q, nm2_q, phase_m2_q;
	logic signed [pwe_pkg::MUL_A_W-1:0] m1_q, m2_q;
	logic signed [pwe_pkg::RES_W-1:0]   sum_q, res_q;
	logic                            status_q;
	logic signed [pwe_pkg::PROD_W-1:0]  prod_q;

	// table access
	logic                        ram_we, ram_re;
	pwe_pkg::entry_t             ram_wdata, rd;

	// divider
	pwe_pkg::div_stat_t                  div_stat;
	logic signed [pwe_pkg::MUL_A_W-1:0]  div_quo;
	logic [pwe_pkg::TIME_W-1:0]          step;

	// combinational datapath
	logic                             in_fire, full, is_last;
	logic signed [pwe_pkg::REL_W-1:0] rel_from, rel_to, len_s, s_rel, e_rel, rd_rel;
	logic                             amp_zero, mom_zero;
	logic                             c_a, c_b, c_c, c_d;
	logic signed [pwe_pkg::REL_W-1:0] d_rel, y_hi, y_lo, y_rel;
	logic signed [pwe_pkg::MUL_A_W-1:0] base, other, x_a, x_b, mul_a, m_new;
	logic signed [pwe_pkg::MUL_B_W-1:0] mul_b;
	logic signed [pwe_pkg::SUM_W-1:0]   nsum;
	logic signed [pwe_pkg::RES_W-1:0]   csum;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == pwe_pkg::ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign full    = (count_q == pwe_pkg::CNT_W'(pwe_pkg::MAX_POINTS));
	assign is_last = (idx_q + pwe_pkg::CNT_W'(1)) == count_q;

	// relative times, exact and signed
	assign rel_from = $signed({2'b0, in_data.time_from}) - $signed({2'b0, start_q});
	assign rel_to   = $signed({2'b0, in_data.time_to}) - $signed({2'b0, start_q});
	assign len_s    = $signed({2'b0, length_q});

	assign amp_zero = (in_data.query_axis != axis_q) || (rel_from < 0) ||
	                  (rel_from > len_s) || (count_q == '0);
	assign mom_zero = (in_data.query_axis != axis_q) || (rel_to < 0) ||
	                  (rel_from > len_s) || (rel_to < rel_from) ||
	                  (count_q < pwe_pkg::CNT_W'(2));

	// segment classification against the freshly read entry
	assign s_rel  = $signed({2'b0, prev_time_q});
	assign rd_rel = $signed({2'b0, rd.tm});
	assign c_a = (t1_q <= s_rel) && (rd_rel <= t2_q);
	assign c_b = (t1_q <= s_rel) && (s_rel <= t2_q);
	assign c_c = (t1_q <= rd_rel) && (rd_rel <= t2_q);
	assign c_d = (s_rel <= t1_q) && (t2_q <= rd_rel);

	// interpolation operands: m1 runs from b back toward a, m2 from a toward b
	assign e_rel = $signed({2'b0, cur_time_q});
	assign step  = cur_time_q - prev_time_q;
	always_comb begin
		if (phase_m2_q) begin
			base  = pwe_pkg::MUL_A_W'(prev_amp_q);
			other = pwe_pkg::MUL_A_W'(cur_amp_q);
			d_rel = t2_q - s_rel;
		end else begin
			base  = pwe_pkg::MUL_A_W'(cur_amp_q);
			other = pwe_pkg::MUL_A_W'(prev_amp_q);
			d_rel = e_rel - t1_q;
		end
	end

	// trapezoid term: (left + right) * width, with clipped ends as needed
	assign x_a   = nm1_q ? m1_q : pwe_pkg::MUL_A_W'(prev_amp_q);
	assign x_b   = nm2_q ? m2_q : pwe_pkg::MUL_A_W'(cur_amp_q);
	assign y_hi  = nm2_q ? t2_q : e_rel;
	assign y_lo  = nm1_q ? t1_q : s_rel;
	assign y_rel = y_hi - y_lo;

	always_comb begin
		if (state_q == pwe_pkg::ST_IMUL) begin
			mul_a = other - base;
			mul_b = $signed(d_rel[pwe_pkg::MUL_B_W-1:0]);
		end else begin
			mul_a = x_a + x_b;
			mul_b = $signed(y_rel[pwe_pkg::MUL_B_W-1:0]);
		end
	end

	assign m_new = base + div_quo;

	// saturating accumulate
	assign nsum = pwe_pkg::SUM_W'(sum_q) + pwe_pkg::SUM_W'(prod_q);
	always_comb begin
		if (nsum > pwe_pkg::SUM_MAX) begin
			csum = pwe_pkg::RES_W'(pwe_pkg::SUM_MAX);
		end else if (nsum < pwe_pkg::SUM_MIN) begin
			csum = pwe_pkg::RES_W'(pwe_pkg::SUM_MIN);
		end else begin
			csum = nsum[pwe_pkg::RES_W-1:0];
		end
	end

	// table port
	assign ram_we    = in_fire && (in_data.opcode == pwe_pkg::OP_LOAD) && !full;
	assign ram_wdata = '{tm: in_data.point_time, amp: in_data.point_amplitude};
	assign ram_re    = (state_q == pwe_pkg::ST_RD);

	pwe_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[pwe_pkg::ADDR_W-1:0]),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q[pwe_pkg::ADDR_W-1:0]),
		.rdata (rd)
	);

	pwe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == pwe_pkg::ST_IDIV),
		.dividend (prod_q),
		.divisor  (step),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pwe_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (in_data.opcode == pwe_pkg::OP_AMP && !amp_zero) begin
						state_d = pwe_pkg::ST_RD;
					end else if (in_data.opcode == pwe_pkg::OP_MOM && !mom_zero) begin
						state_d = pwe_pkg::ST_RD;
					end else begin
						state_d = pwe_pkg::ST_DONE;
					end
				end
			end
			pwe_pkg::ST_RD: state_d = pwe_pkg::ST_EVAL;
			pwe_pkg::ST_EVAL: begin
				if (op_q == pwe_pkg::OP_AMP) begin
					if (rd_rel >= t2_q) begin
						state_d = (idx_q == '0) ? pwe_pkg::ST_DONE : pwe_pkg::ST_IMUL;
					end else begin
						state_d = is_last ? pwe_pkg::ST_DONE : pwe_pkg::ST_RD;
					end
				end else if (idx_q == '0) begin
					state_d = pwe_pkg::ST_RD;
				end else if ((rd.tm > prev_time_q) && (c_a || c_b || c_c || c_d)) begin
					state_d = c_a ? pwe_pkg::ST_FMUL : pwe_pkg::ST_IMUL;
				end else begin
					state_d = is_last ? pwe_pkg::ST_DONE : pwe_pkg::ST_RD;
				end
			end
			pwe_pkg::ST_IMUL: state_d = pwe_pkg::ST_IDIV;
			pwe_pkg::ST_IDIV: state_d = pwe_pkg::ST_IWAIT;
			pwe_pkg::ST_IWAIT: begin
				if (div_stat.done) begin
					if (op_q == pwe_pkg::OP_AMP) begin
						state_d = pwe_pkg::ST_DONE;
					end else if (!phase_m2_q && nm2_q) begin
						state_d = pwe_pkg::ST_IMUL;
					end else begin
						state_d = pwe_pkg::ST_FMUL;
					end
				end
			end
			pwe_pkg::ST_FMUL: state_d = pwe_pkg::ST_ACC;
			pwe_pkg::ST_ACC:  state_d = is_last ? pwe_pkg::ST_DONE : pwe_pkg::ST_RD;
			pwe_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = pwe_pkg::ST_IDLE;
				end
			end
			default: state_d = pwe_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pwe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q      <= pwe_pkg::AXIS_W'(1);
			start_q     <= '0;
			length_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					pwe_pkg::CFG_AXIS:   axis_q   <= cfg_data[pwe_pkg::AXIS_W-1:0];
					pwe_pkg::CFG_START:  start_q  <= cfg_data;
					pwe_pkg::CFG_LENGTH: length_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_fire && in_data.opcode == pwe_pkg::OP_CLEAR) begin
				count_q <= '0;
			end else if (ram_we) begin
				count_q <= count_q + pwe_pkg::CNT_W'(1);
			end
			if (state_q == pwe_pkg::ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			pwe_pkg::ST_IDLE: begin
				if (in_fire) begin
					op_q     <= in_data.opcode;
					t1_q     <= rel_from;
					t2_q     <= (in_data.opcode == pwe_pkg::OP_AMP) ? rel_from : rel_to;
					idx_q    <= '0;
					sum_q    <= '0;
					res_q    <= '0;
					status_q <= (in_data.opcode == pwe_pkg::OP_LOAD) && full;
				end
			end
			pwe_pkg::ST_EVAL: begin
				cur_time_q <= rd.tm;
				cur_amp_q  <= rd.amp;
				nm1_q      <= !c_a && !c_b;
				nm2_q      <= !c_a && !c_c;
				phase_m2_q <= (op_q == pwe_pkg::OP_AMP) || c_b;
				if (state_d == pwe_pkg::ST_RD) begin
					prev_time_q <= rd.tm;
					prev_amp_q  <= rd.amp;
					idx_q       <= idx_q + pwe_pkg::CNT_W'(1);
				end
				if (state_d == pwe_pkg::ST_DONE && op_q == pwe_pkg::OP_MOM) begin
					res_q <= sum_q;
				end
			end
			pwe_pkg::ST_IWAIT: begin
				if (div_stat.done) begin
					if (op_q == pwe_pkg::OP_AMP) begin
						res_q <= pwe_pkg::RES_W'(m_new);
					end
					if (phase_m2_q) begin
						m2_q <= m_new;
					end else begin
						m1_q       <= m_new;
						phase_m2_q <= 1'b1;
					end
				end
			end
			pwe_pkg::ST_ACC: begin
				sum_q       <= csum;
				res_q       <= csum;
				prev_time_q <= cur_time_q;
				prev_amp_q  <= cur_amp_q;
				idx_q       <= idx_q + pwe_pkg::CNT_W'(1);
			end
			pwe_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_q <= '{result_value: res_q, status: status_q};
				end
			end
			default: ;
		endcase
		if (state_q == pwe_pkg::ST_IMUL || state_q == pwe_pkg::ST_FMUL) begin
			prod_q <= pwe_pkg::PROD_W'(mul_a) * pwe_pkg::PROD_W'(mul_b);
		end
	end

	// checks
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pwe_pkg::CNT_W'(pwe_pkg::MAX_POINTS))
		else $error("table count past capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> state_q == pwe_pkg::ST_IWAIT)
		else $error("divider running outside its wait state");

	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == pwe_pkg::ST_IDLE && !full))
		else $error("table write outside an accepted load");

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (in_data.opcode == pwe_pkg::OP_CLEAR ||
		             in_data.opcode == pwe_pkg::OP_LOAD))
		|=> state_q == pwe_pkg::ST_DONE)
		else $error("clear or load did not finish at once");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pwe_pkg::ST_DONE && (!out_valid_q || out_ready)) |=> out_valid_q)
		else $error("finished result not presented");

endmodule
